// ===== hdl/qtp_pkg.sv =====
// Shared types, constants and saturating arithmetic helpers for the quintic trajectory point core.
`default_nettype none

package qtp_pkg;

  // Default fraction bits of all fixed-point fields
  localparam int unsigned FRAC_BITS_DEF = 16;
  // Fraction bits of normalised time s and of the reciprocal
  localparam int unsigned SFRAC = 31;
  localparam int unsigned RFRAC = 62;
  // Register stages from the input register to the output register
  localparam int unsigned LAT = 37;

  typedef logic signed [63:0] qtp_wide_t;

  // Saturation limit of every intermediate: 2^62 - 1
  localparam qtp_wide_t WIDE_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        [31:0] start_time;
    logic        [31:0] end_time;
    logic        [31:0] now_time;
    logic signed [31:0] start_pos;
    logic signed [31:0] end_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] end_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_acc;
  } qtp_req_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               zero_span;
  } qtp_res_t;

  function automatic qtp_wide_t wclamp(qtp_wide_t v);
    qtp_wide_t r;
    r = v;
    if (v > WIDE_LIM) r = WIDE_LIM;
    if (v < -WIDE_LIM) r = -WIDE_LIM;
    return r;
  endfunction

  // Saturating add: both operands clamped first, so the sum cannot wrap
  function automatic qtp_wide_t wadd(qtp_wide_t a, qtp_wide_t b);
    return wclamp(wclamp(a) + wclamp(b));
  endfunction

  function automatic logic signed [31:0] sat32(qtp_wide_t v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/quintic_trajectory_point_core.sv =====
// Quintic trajectory point core: a result leaves the output register for each accepted request;
// one request per cycle sustained while req_stall is low.
// The latency is set by the 16-stage reciprocal divider (four quotient bits a stage) and the
// chain of multipliers forming s..s^5 and the final scaling by the reciprocal.
// A stalled output result moves to a skid register; the pipeline holds while that is full.
// Synchronous reset clears the valid bits and the skid valid flag; the datapath is not reset.
`default_nettype none

module quintic_trajectory_point_core
  import qtp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_stall,
  input  wire qtp_req_t req_data,
  output logic          res_valid,
  input  wire logic     res_stall,
  output qtp_res_t      res_data
);

  logic en;
  logic skid_valid;
  qtp_res_t skid, outr;
  logic [LAT-1:0] vp;
  logic s0_valid;

  // input stage registers
  logic signed [32:0] s0_span, s0_tau, s0_h;
  logic signed [31:0] s0_p0, s0_v0, s0_a0;
  logic signed [37:0] s0_m8, s0_m14, s0_m6;
  logic signed [35:0] s0_n3a, s0_n3b, s0_nd;
  logic               s0_zero, s0_neg;
  logic        [31:0] s0_d;

  logic signed [32:0] span_c;

  qtp_wide_t t2, x1, y1, z1, tt, pv, va;
  qtp_wide_t x2, y2, z2, p2;
  logic signed [35:0] n3a2, n3b2, nd2;
  logic signed [31:0] a0_2, p0_4, v0_4, a0_36;
  logic signed [32:0] h4, tau17;
  qtp_wide_t x1_4, y1_4, z1_4, pv4, va4;
  qtp_wide_t c_a, c_b, c_c, pb, vb;
  qtp_wide_t rcp, s1, s2, s3, s4, s5;
  qtp_wide_t s1_21, s1_23, s1_25, s1_27, s2_27, s3_27, s4_27;
  qtp_wide_t ca27, cb27, cc27;
  qtp_wide_t pa, pbb, pc, vx, vy, vz, ax, ay, az;
  qtp_wide_t pa31, pb31, pc31, v3, v4, v5, a6, a12, a20;
  qtp_wide_t polyp, polyv, polya;
  qtp_wide_t r32, r34, half, vt, at1, at2, half36, vt36, pb36, vb36;
  logic zero36;

  // pipeline advances whenever the skid register is empty
  assign en        = !skid_valid;
  assign req_stall = skid_valid;

  assign span_c = $signed({1'b0, req_data.end_time}) - $signed({1'b0, req_data.start_time});

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      vp       <= '0;
    end else if (en) begin
      s0_valid <= req_valid;
      vp       <= {vp[LAT-2:0], s0_valid};
    end
  end

  // differences and boundary combinations
  always_ff @(posedge clk) begin
    if (en) begin
      s0_span <= span_c;
      s0_tau  <= $signed({1'b0, req_data.now_time}) - $signed({1'b0, req_data.start_time});
      s0_h    <= 33'(req_data.end_pos) - 33'(req_data.start_pos);
      s0_p0   <= req_data.start_pos;
      s0_v0   <= req_data.start_vel;
      s0_a0   <= req_data.start_acc;
      s0_m8   <= 38'(req_data.end_vel) * 38'sd8 + 38'(req_data.start_vel) * 38'sd12;
      s0_m14  <= 38'(req_data.end_vel) * 38'sd14 + 38'(req_data.start_vel) * 38'sd16;
      s0_m6   <= (38'(req_data.end_vel) + 38'(req_data.start_vel)) * 38'sd6;
      s0_n3a  <= 36'(req_data.start_acc) * 36'sd3 - 36'(req_data.end_acc);
      s0_n3b  <= 36'(req_data.start_acc) * 36'sd3 - 36'(req_data.end_acc) * 36'sd2;
      s0_nd   <= 36'(req_data.end_acc) - 36'(req_data.start_acc);
      s0_zero <= (req_data.end_time == req_data.start_time);
      s0_neg  <= span_c[32];
      s0_d    <= span_c[32] ? 32'(-span_c) : span_c[31:0];
    end
  end

  // span and local time products
  qtp_wmul #(.SH(FRAC_BITS)) u_t2 (.clk, .en, .a(64'(s0_span)), .b(64'(s0_span)), .y(t2));
  qtp_wmul #(.SH(FRAC_BITS)) u_x1 (.clk, .en, .a(64'(s0_m8)),   .b(64'(s0_span)), .y(x1));
  qtp_wmul #(.SH(FRAC_BITS)) u_y1 (.clk, .en, .a(64'(s0_m14)),  .b(64'(s0_span)), .y(y1));
  qtp_wmul #(.SH(FRAC_BITS)) u_z1 (.clk, .en, .a(64'(s0_m6)),   .b(64'(s0_span)), .y(z1));
  qtp_wmul #(.SH(FRAC_BITS)) u_tt (.clk, .en, .a(64'(s0_tau)),  .b(64'(s0_tau)),  .y(tt));
  qtp_wmul #(.SH(FRAC_BITS)) u_pv (.clk, .en, .a(64'(s0_v0)),   .b(64'(s0_tau)),  .y(pv));
  qtp_wmul #(.SH(FRAC_BITS)) u_va (.clk, .en, .a(64'(s0_a0)),   .b(64'(s0_tau)),  .y(va));

  qtp_dly #(.W(36), .N(2)) d_n3a (.clk, .en, .din(s0_n3a), .dout(n3a2));
  qtp_dly #(.W(36), .N(2)) d_n3b (.clk, .en, .din(s0_n3b), .dout(n3b2));
  qtp_dly #(.W(36), .N(2)) d_nd  (.clk, .en, .din(s0_nd),  .dout(nd2));
  qtp_dly #(.W(32), .N(2)) d_a02 (.clk, .en, .din(s0_a0),  .dout(a0_2));

  // T^2 terms and the tau^2 position term
  qtp_wmul #(.SH(FRAC_BITS))     u_x2 (.clk, .en, .a(64'(n3a2)), .b(t2), .y(x2));
  qtp_wmul #(.SH(FRAC_BITS))     u_y2 (.clk, .en, .a(64'(n3b2)), .b(t2), .y(y2));
  qtp_wmul #(.SH(FRAC_BITS))     u_z2 (.clk, .en, .a(64'(nd2)),  .b(t2), .y(z2));
  qtp_wmul #(.SH(FRAC_BITS + 1)) u_p2 (.clk, .en, .a(64'(a0_2)), .b(tt), .y(p2));

  qtp_dly #(.W(33), .N(4)) d_h4  (.clk, .en, .din(s0_h),  .dout(h4));
  qtp_dly #(.W(32), .N(4)) d_p04 (.clk, .en, .din(s0_p0), .dout(p0_4));
  qtp_dly #(.W(32), .N(4)) d_v04 (.clk, .en, .din(s0_v0), .dout(v0_4));
  qtp_dly #(.W(64), .N(2)) d_x1  (.clk, .en, .din(x1), .dout(x1_4));
  qtp_dly #(.W(64), .N(2)) d_y1  (.clk, .en, .din(y1), .dout(y1_4));
  qtp_dly #(.W(64), .N(2)) d_z1  (.clk, .en, .din(z1), .dout(z1_4));
  qtp_dly #(.W(64), .N(2)) d_pv  (.clk, .en, .din(pv), .dout(pv4));
  qtp_dly #(.W(64), .N(2)) d_va  (.clk, .en, .din(va), .dout(va4));

  // coefficients A, B, C and the low-order parts of position and velocity
  always_ff @(posedge clk) begin
    if (en) begin
      c_a <= wadd(wadd(64'(h4) * 64'sd20, -x1_4), -x2);
      c_b <= wadd(wadd(-(64'(h4) * 64'sd30), y1_4), y2);
      c_c <= wadd(wadd(64'(h4) * 64'sd12, -z1_4), z2);
      pb  <= wadd(wadd(64'(p0_4), pv4), p2);
      vb  <= wadd(64'(v0_4), va4);
    end
  end

  // reciprocal of the span
  qtp_recip u_rcp (.clk, .en, .d(s0_d), .neg(s0_neg), .r(rcp));

  qtp_dly #(.W(33), .N(17)) d_tau (.clk, .en, .din(s0_tau), .dout(tau17));

  // normalised time and its powers
  qtp_wmul #(.SH(RFRAC - SFRAC)) u_s1 (.clk, .en, .a(64'(tau17)), .b(rcp), .y(s1));
  qtp_wmul #(.SH(SFRAC)) u_s2 (.clk, .en, .a(s1), .b(s1),    .y(s2));
  qtp_dly #(.W(64), .N(2)) d_s121 (.clk, .en, .din(s1),    .dout(s1_21));
  qtp_wmul #(.SH(SFRAC)) u_s3 (.clk, .en, .a(s2), .b(s1_21), .y(s3));
  qtp_dly #(.W(64), .N(2)) d_s123 (.clk, .en, .din(s1_21), .dout(s1_23));
  qtp_wmul #(.SH(SFRAC)) u_s4 (.clk, .en, .a(s3), .b(s1_23), .y(s4));
  qtp_dly #(.W(64), .N(2)) d_s125 (.clk, .en, .din(s1_23), .dout(s1_25));
  qtp_wmul #(.SH(SFRAC)) u_s5 (.clk, .en, .a(s4), .b(s1_25), .y(s5));
  qtp_dly #(.W(64), .N(2)) d_s127 (.clk, .en, .din(s1_25), .dout(s1_27));
  qtp_dly #(.W(64), .N(6)) d_s227 (.clk, .en, .din(s2), .dout(s2_27));
  qtp_dly #(.W(64), .N(4)) d_s327 (.clk, .en, .din(s3), .dout(s3_27));
  qtp_dly #(.W(64), .N(2)) d_s427 (.clk, .en, .din(s4), .dout(s4_27));

  qtp_dly #(.W(64), .N(22)) d_ca (.clk, .en, .din(c_a), .dout(ca27));
  qtp_dly #(.W(64), .N(22)) d_cb (.clk, .en, .din(c_b), .dout(cb27));
  qtp_dly #(.W(64), .N(22)) d_cc (.clk, .en, .din(c_c), .dout(cc27));

  // coefficient times power of s for the three derivatives
  qtp_wmul #(.SH(SFRAC)) u_pa (.clk, .en, .a(ca27), .b(s3_27), .y(pa));
  qtp_wmul #(.SH(SFRAC)) u_pb (.clk, .en, .a(cb27), .b(s4_27), .y(pbb));
  qtp_wmul #(.SH(SFRAC)) u_pc (.clk, .en, .a(cc27), .b(s5),    .y(pc));
  qtp_wmul #(.SH(SFRAC)) u_vx (.clk, .en, .a(ca27), .b(s2_27), .y(vx));
  qtp_wmul #(.SH(SFRAC)) u_vy (.clk, .en, .a(cb27), .b(s3_27), .y(vy));
  qtp_wmul #(.SH(SFRAC)) u_vz (.clk, .en, .a(cc27), .b(s4_27), .y(vz));
  qtp_wmul #(.SH(SFRAC)) u_ax (.clk, .en, .a(ca27), .b(s1_27), .y(ax));
  qtp_wmul #(.SH(SFRAC)) u_ay (.clk, .en, .a(cb27), .b(s2_27), .y(ay));
  qtp_wmul #(.SH(SFRAC)) u_az (.clk, .en, .a(cc27), .b(s3_27), .y(az));

  // derivative weights
  qtp_wmul #(.SH(0)) u_v3  (.clk, .en, .a(vx), .b(64'sd3),  .y(v3));
  qtp_wmul #(.SH(0)) u_v4  (.clk, .en, .a(vy), .b(64'sd4),  .y(v4));
  qtp_wmul #(.SH(0)) u_v5  (.clk, .en, .a(vz), .b(64'sd5),  .y(v5));
  qtp_wmul #(.SH(0)) u_a6  (.clk, .en, .a(ax), .b(64'sd6),  .y(a6));
  qtp_wmul #(.SH(0)) u_a12 (.clk, .en, .a(ay), .b(64'sd12), .y(a12));
  qtp_wmul #(.SH(0)) u_a20 (.clk, .en, .a(az), .b(64'sd20), .y(a20));
  qtp_dly #(.W(64), .N(2)) d_pa (.clk, .en, .din(pa),  .dout(pa31));
  qtp_dly #(.W(64), .N(2)) d_pb (.clk, .en, .din(pbb), .dout(pb31));
  qtp_dly #(.W(64), .N(2)) d_pc (.clk, .en, .din(pc),  .dout(pc31));

  // polynomial sums
  always_ff @(posedge clk) begin
    if (en) begin
      polyp <= wadd(wadd(pa31, pb31), pc31);
      polyv <= wadd(wadd(v3, v4), v5);
      polya <= wadd(wadd(a6, a12), a20);
    end
  end

  qtp_dly #(.W(64), .N(15)) d_r32 (.clk, .en, .din(rcp), .dout(r32));
  qtp_dly #(.W(64), .N(2))  d_r34 (.clk, .en, .din(r32), .dout(r34));

  // halving and division by T, T^2
  qtp_wmul #(.SH(1)) u_half (.clk, .en, .a(polyp), .b(64'sd1), .y(half));
  qtp_wmul #(.SH(RFRAC - FRAC_BITS + 1)) u_vt  (.clk, .en, .a(polyv), .b(r32), .y(vt));
  qtp_wmul #(.SH(RFRAC - FRAC_BITS + 1)) u_at1 (.clk, .en, .a(polya), .b(r32), .y(at1));
  qtp_wmul #(.SH(RFRAC - FRAC_BITS))     u_at2 (.clk, .en, .a(at1),   .b(r34), .y(at2));

  qtp_dly #(.W(64), .N(2))  d_half (.clk, .en, .din(half),    .dout(half36));
  qtp_dly #(.W(64), .N(2))  d_vt   (.clk, .en, .din(vt),      .dout(vt36));
  qtp_dly #(.W(64), .N(31)) d_pb36 (.clk, .en, .din(pb),      .dout(pb36));
  qtp_dly #(.W(64), .N(31)) d_vb36 (.clk, .en, .din(vb),      .dout(vb36));
  qtp_dly #(.W(32), .N(34)) d_a036 (.clk, .en, .din(a0_2),    .dout(a0_36));
  qtp_dly #(.W(1),  .N(36)) d_zero (.clk, .en, .din(s0_zero), .dout(zero36));

  // output register: final sums, saturation, zero span override
  always_ff @(posedge clk) begin
    if (en) begin
      if (zero36) begin
        outr.position     <= '0;
        outr.velocity     <= '0;
        outr.acceleration <= '0;
        outr.zero_span    <= 1'b1;
      end else begin
        outr.position     <= sat32(wadd(pb36, half36));
        outr.velocity     <= sat32(wadd(vb36, vt36));
        outr.acceleration <= sat32(wadd(64'(a0_36), at2));
        outr.zero_span    <= 1'b0;
      end
    end
  end

  // skid register catches a result stalled at the output
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (vp[LAT-1] && res_stall) begin
        skid_valid <= 1'b1;
      end
    end else if (!res_stall) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && vp[LAT-1] && res_stall) begin
      skid <= outr;
    end
  end

  assign res_valid = skid_valid | vp[LAT-1];
  assign res_data  = skid_valid ? skid : outr;

endmodule

`default_nettype wire

// ===== hdl/qtp_dly.sv =====
// Enable-gated register delay line used to align operands across the pipeline.
`default_nettype none

module qtp_dly #(
  parameter int unsigned W = 64,
  parameter int unsigned N = 2
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] pipe [N];

  // shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= din;
      for (int i = 1; i < int'(N); i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign dout = pipe[N-1];

endmodule

`default_nettype wire

// ===== hdl/qtp_wmul.sv =====
// Two-stage signed 64x64 multiply with rounding shift and saturation to +-(2^62-1).
`default_nettype none

module qtp_wmul
  import qtp_pkg::*;
#(
  parameter int unsigned SH = 0
) (
  input  wire logic      clk,
  input  wire logic      en,
  input  wire qtp_wide_t a,
  input  wire qtp_wide_t b,
  output qtp_wide_t      y
);

  // half an output LSB, zero when there is no shift
  localparam logic [127:0] RND = (128'd1 << SH) >> 1;

  logic [63:0]  ua, ub;
  logic [63:0]  pp00, pp01, pp10, pp11;
  logic         neg;
  logic [127:0] full, shr;
  logic [63:0]  mag;

  assign ua = a[63] ? (~a + 64'd1) : a;
  assign ub = b[63] ? (~b + 64'd1) : b;

  // stage 1: magnitudes split into 32-bit halves, four partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= ua[31:0]  * ub[31:0];
      pp01 <= ua[31:0]  * ub[63:32];
      pp10 <= ua[63:32] * ub[31:0];
      pp11 <= ua[63:32] * ub[63:32];
      neg  <= a[63] ^ b[63];
    end
  end

  // stage 2: combine, round half away from zero, shift, saturate
  assign full = {pp11, 64'd0} + {32'd0, pp01, 32'd0} + {32'd0, pp10, 32'd0}
              + {64'd0, pp00} + RND;
  assign shr  = full >> SH;
  assign mag  = (|shr[127:62]) ? WIDE_LIM : shr[63:0];

  always_ff @(posedge clk) begin
    if (en) begin
      y <= neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/qtp_recip.sv =====
// Pipelined restoring divider giving round(2^62 / |T|) with the sign of T.
`default_nettype none

module qtp_recip
  import qtp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] d,
  input  wire logic        neg,
  output qtp_wide_t        r
);

  localparam int unsigned STEPS = 4;
  localparam int unsigned NSTG  = 64 / STEPS;

  logic [32:0] rem [NSTG];
  logic [63:0] quo [NSTG];
  logic [31:0] dv  [NSTG];
  logic        sg  [NSTG];
  logic [63:0] qr;

  // four quotient bits of 2^62 / dd, most significant first
  function automatic logic [96:0] step4(logic [32:0] rm_in, logic [63:0] q_in,
                                        logic [31:0] dd, int unsigned base);
    logic [32:0] rm;
    logic [63:0] q;
    int unsigned bi;
    rm = rm_in;
    q  = q_in;
    for (int unsigned j = 0; j < STEPS; j++) begin
      bi = base - j;
      rm = {rm[31:0], (bi == RFRAC)};
      if (rm >= {1'b0, dd}) begin
        rm = rm - {1'b0, dd};
        q  = {q[62:0], 1'b1};
      end else begin
        q  = {q[62:0], 1'b0};
      end
    end
    return {rm, q};
  endfunction

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          {rem[g], quo[g]} <= step4(33'd0, 64'd0, d, 63);
          dv[g] <= d;
          sg[g] <= neg;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          {rem[g], quo[g]} <= step4(rem[g-1], quo[g-1], dv[g-1],
                                    63 - g * STEPS);
          dv[g] <= dv[g-1];
          sg[g] <= sg[g-1];
        end
      end
    end
  end

  // round: bump when the remainder is at least half the divisor
  assign qr = quo[NSTG-1]
            + 64'({rem[NSTG-1], 1'b0} >= {2'b00, dv[NSTG-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      r <= sg[NSTG-1] ? -$signed(qr) : $signed(qr);
    end
  end

endmodule

`default_nettype wire
